// ===== hdl/binomial_row_generator_assert.svh =====
// ---------------------------------------------------------------------------
// binomial_row_generator assertion macros
// shared property forms for the row generator's checks
// ---------------------------------------------------------------------------
`ifndef BINOMIAL_ROW_GENERATOR_ASSERT_SVH
`define BINOMIAL_ROW_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BRG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/brg_pkg.sv =====
// ---------------------------------------------------------------------------
// brg_pkg
// widths and controller-to-datapath command type for the row generator
// ---------------------------------------------------------------------------
package brg_pkg;

  localparam int COEF_W      = 60;
  localparam int POS_W       = 6;
  localparam int ROW_DEPTH   = 64;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
    logic             add;
    logic             first;
    logic             init;
    logic             load;
    logic [POS_W-1:0] pos;
    logic             last;
  } brg_cmd_t;

endpackage

// ===== hdl/brg_ram.sv =====
// ---------------------------------------------------------------------------
// brg_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module brg_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/brg_ctrl.sv =====
// ---------------------------------------------------------------------------
// brg_ctrl
// sequencer for row build-up and coefficient read-out
// ---------------------------------------------------------------------------
`include "binomial_row_generator_assert.svh"

module brg_ctrl import brg_pkg::*; #(
  parameter int MAX_ROW = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [POS_W-1:0] in_row,
  input  logic             out_free,
  output brg_cmd_t         cmd
);

  typedef enum logic [2:0] {
    IDLE,
    INIT,
    ADD,
    DRAIN,
    EMIT_RD,
    EMIT_LD
  } state_t;

  state_t           state;
  logic [POS_W-1:0] n;
  logic [POS_W-1:0] r;
  logic [POS_W-1:0] k;
  logic [POS_W-1:0] n_sat;

  assign n_sat    = (int'(in_row) > MAX_ROW) ? POS_W'(MAX_ROW) : in_row;
  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      n     <= '0;
      r     <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            n     <= n_sat;
            state <= INIT;
          end
        end
        INIT: begin
          r <= POS_W'(1);
          if (n == '0) begin
            k     <= '0;
            state <= EMIT_RD;
          end else begin
            k     <= POS_W'(1);
            state <= ADD;
          end
        end
        ADD: begin
          if (k == POS_W'(1)) begin
            state <= DRAIN;
          end else begin
            k <= k - POS_W'(1);
          end
        end
        DRAIN: begin
          if (r == n) begin
            k     <= '0;
            state <= EMIT_RD;
          end else begin
            r     <= r + POS_W'(1);
            k     <= r + POS_W'(1);
            state <= ADD;
          end
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          if (out_free) begin
            if (k == n) begin
              state <= IDLE;
            end else begin
              k     <= k + POS_W'(1);
              state <= EMIT_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_en   = (state == ADD) || (state == EMIT_RD);
    cmd.rd_addr = (state == ADD) ? (k - POS_W'(1)) : k;
    cmd.add     = (state == ADD);
    cmd.first   = (state == ADD) && (k == r);
    cmd.init    = (state == INIT);
    cmd.load    = (state == EMIT_LD) && out_free;
    cmd.pos     = k;
    cmd.last    = (k == n);
  end

  `BRG_ASSERT_IMP(a_load_free, cmd.load, out_free, "coefficient loaded into a busy output")
  `BRG_ASSERT_IMP(a_add_in_row, cmd.add, cmd.rd_addr < r, "addition reads beyond current row")
  `BRG_ASSERT_NXT(a_accept_init, in_valid && in_ready, cmd.init, "accepted row not started")

endmodule

// ===== hdl/brg_dpath.sv =====
// ---------------------------------------------------------------------------
// brg_dpath
// working row ram, shared adder and output register
// ---------------------------------------------------------------------------
module brg_dpath import brg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  brg_cmd_t          cmd,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COEF_W-1:0] coef,
  output logic [POS_W-1:0]  pos,
  output logic              last
);

  logic              wr_pend;
  logic [POS_W-1:0]  wr_addr;
  logic [COEF_W-1:0] hold;
  logic [COEF_W-1:0] rdata;
  logic [COEF_W-1:0] sum;
  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  logic [COEF_W-1:0] ram_wdata;

  // new row[k] = old row[k] + old row[k-1], hold keeps old row[k]
  assign sum       = hold + rdata;
  assign ram_we    = cmd.init || wr_pend;
  assign ram_waddr = cmd.init ? '0 : wr_addr;
  assign ram_wdata = cmd.init ? COEF_W'(1) : sum;
  assign out_free  = !out_valid || out_ready;

  brg_ram #(
    .WIDTH (COEF_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_pend <= cmd.add;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= cmd.rd_addr + POS_W'(1);
    if (wr_pend) begin
      hold <= rdata;
    end else if (cmd.first) begin
      hold <= '0;
    end
    if (cmd.load) begin
      coef <= rdata;
      pos  <= cmd.pos;
      last <= cmd.last;
    end
  end

endmodule

// ===== hdl/binomial_row_generator.sv =====
// ---------------------------------------------------------------------------
// binomial_row_generator
// emits row n of pascal's triangle as n+1 exact unsigned coefficients
// ---------------------------------------------------------------------------
// A row number is taken when the block is idle and builds the row in a
// 64-entry working ram through one shared 60-bit adder, one addition per
// cycle, then reads the coefficients out in order with tlast on C(n,n).
// Only the row number's low six bits are used; values above MAX_ROW are
// treated as MAX_ROW. A row n occupies the block for its additions, a
// turnaround state per row, and a read and a load state per coefficient
// through the ram's registered read port. The ram needs no clearing
// pass; the next row number is accepted once the last transaction is loaded.
module binomial_row_generator import brg_pkg::*; #(
  parameter int MAX_ROW = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // row_number
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // coefficient, position
  output logic                   m_axis_tlast
);

  brg_cmd_t          cmd;
  logic              out_free;
  logic [COEF_W-1:0] coef;
  logic [POS_W-1:0]  pos;

  brg_ctrl #(
    .MAX_ROW (MAX_ROW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_row   (s_axis_tdata[POS_W-1:0]),
    .out_free (out_free),
    .cmd      (cmd)
  );

  brg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .coef      (coef),
    .pos       (pos),
    .last      (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - COEF_W - POS_W)'(0), pos, coef};

endmodule

// ===== sim/binomial_row_generator_tb.sv =====
// ---------------------------------------------------------------------------
// binomial_row_generator_tb
// self-checking regression for the pascal's triangle row generator
// ---------------------------------------------------------------------------
// Row numbers are queued by the stimulus process and fed to the block by a
// driver on the falling edge. At each rising edge a monitor checks every
// output transaction against the oldest predicted coefficient. When a row
// number is accepted, its whole row is built in the bench by Pascal
// additions and queued as predictions. The run starts with directed rows:
// zero, one, the maximum, and alternating bit patterns. It then runs three
// random phases with different stall patterns on each side, and drains
// fully between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module binomial_row_generator_tb;
  import brg_pkg::*;

  localparam int ROW_LIMIT = 63;
  localparam int RAND_ROWS = 28;

  typedef struct {
    logic [COEF_W-1:0] coefficient;
    logic [POS_W-1:0]  position;
    logic              last;
  } coef_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // row_number
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // coefficient, position
  logic                   m_axis_tlast;

  logic [POS_W-1:0] row_q[$];
  coef_t            coef_q[$];
  logic             in_fire = 1'b0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               errors = 0;

  binomial_row_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // builds row n by in-place pascal additions and queues its coefficients
  function automatic void push_pascal_row(input logic [POS_W-1:0] row_number);
    logic [COEF_W-1:0] pascal[ROW_DEPTH];
    int                n;
    coef_t             c;
    n = int'(row_number);
    if (n > ROW_LIMIT) n = ROW_LIMIT;
    foreach (pascal[i]) pascal[i] = '0;
    pascal[0] = COEF_W'(1);
    for (int r = 1; r <= n; r++)
      for (int k = r; k >= 1; k--)
        pascal[k] = pascal[k] + pascal[k-1];
    for (int k = 0; k <= n; k++) begin
      c.coefficient = pascal[k];
      c.position    = POS_W'(k);
      c.last        = (k == n);
      coef_q.push_back(c);
    end
  endfunction

  // mostly full-range rows, many short ones, a few extremes
  function automatic logic [POS_W-1:0] pick_row();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10)
      pick_row = ($urandom_range(1) == 1) ? POS_W'(63) : POS_W'(0);
    else if (roll < 45)
      pick_row = POS_W'($urandom_range(15));
    else
      pick_row = POS_W'($urandom);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (row_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(row_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else     m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and predictor
  always @(posedge clk) begin
    coef_t                want;
    logic [COEF_W-1:0] got_coef;
    logic [POS_W-1:0]  got_pos;
    got_coef = m_axis_tdata[COEF_W-1:0];
    got_pos  = m_axis_tdata[COEF_W+POS_W-1:COEF_W];
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (coef_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transaction: coef %0d pos %0d last %0b",
                     got_coef, got_pos, m_axis_tlast);
        end else begin
          want = coef_q.pop_front();
          if (got_coef !== want.coefficient || got_pos !== want.position ||
              m_axis_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected coef %0d pos %0d last %0b, ",
                        "got coef %0d pos %0d last %0b"},
                       want.coefficient, want.position, want.last,
                       got_coef, got_pos, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        push_pascal_row(s_axis_tdata[POS_W-1:0]);
    end
  end

  initial begin
    logic [POS_W-1:0] directed[17] = '{0, 1, 2, 63, 62, 0, 32, 31, 21, 42, 3,
                                       63, 0, 60, 1, 15, 48};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 87;
    foreach (directed[i]) row_q.push_back(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      while (row_q.size() != 0 || s_axis_tvalid || coef_q.size() != 0)
        @(posedge clk);
      @(negedge clk);
      if (phase == 1) begin
        send_idle_pct = 87;
        recv_idle_pct = 9;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < RAND_ROWS; i++) row_q.push_back(pick_row());
    end

    while (row_q.size() != 0 || s_axis_tvalid || coef_q.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);

    if (coef_q.size() != 0) begin
      errors++;
      $display("%0d predicted transactions never arrived", coef_q.size());
    end
    if (errors == 0)
      $display("binomial_row_generator regression: pass");
    else
      $display("binomial_row_generator regression: fail");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("binomial_row_generator regression: fail");
    $finish;
  end

endmodule
